>>> hw/rtl/cdt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the countdown timer slot bank.
package cdt_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int IDX_W  = (SLOT_W > 3) ? SLOT_W : 3;

  localparam logic [8:0]  MAX_MINUTES  = 9'd480;
  localparam logic [14:0] SECS_PER_MIN = 15'd60;

  typedef enum logic [2:0] {
    MODE_CREATE   = 3'd0,
    MODE_START    = 3'd1,
    MODE_PAUSE    = 3'd2,
    MODE_RESUME   = 3'd3,
    MODE_STOP     = 3'd4,
    MODE_STOP_ALL = 3'd5,
    MODE_QUERY    = 3'd6,
    MODE_TICK     = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RUN    = 3'd1,
    PH_PAUSE  = 3'd2,
    PH_DONE   = 3'd3,
    PH_CANCEL = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ARG      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_STATE    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] slot_index;
    logic [1:0] task_type;
    logic [8:0] length_minutes;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  result_slot;
    logic [2:0]  slot_state;
    logic [1:0]  slot_type;
    logic [8:0]  slot_duration;
    logic [14:0] slot_remaining;
    logic [3:0]  running_count;
    logic [3:0]  affected_count;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;
  } dp_stat_t;

  function automatic logic [3:0] sat4(input logic [CNT_W-1:0] n);
    logic [3:0] r;
    if (32'(n) > 15) r = 4'd15;
    else r = 4'(n);
    return r;
  endfunction

endpackage

>>> hw/rtl/countdown_timer_slot_bank.sv
`timescale 1ns / 1ps
// Countdown timer slot bank: a bank of SLOTS countdown slots driven by one command per word.
//
// The cmd channel (cmd_valid/cmd_ready/cmd) takes one command word: create, start, pause,
// resume, stop, stop-all, query or the one-second tick. The rsp channel
// (rsp_valid/rsp_ready/rsp) returns exactly one response word per command.
// Every command walks all slots, one slot per cycle through a single update
// unit, and the response word is registered at the end of the walk. The block
// handles one command at a time: cmd_ready is high only while nothing is in
// flight, so the next command is taken in the cycle after the response is taken.
// If the receiver stalls, the response word is held in its output register and
// cmd_ready stays low until rsp_ready is seen.
// Reset (rst, synchronous) marks every slot free and returns the controller to
// idle; slot contents are not cleared, as a slot is only read once it is used.
module countdown_timer_slot_bank (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  cdt_pkg::cmd_t  cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output cdt_pkg::rsp_t  rsp
);

  cdt_pkg::ctrl_cmd_t ctl;
  cdt_pkg::dp_stat_t  stat;

  cdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  cdt_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .ctl  (ctl),
    .stat (stat),
    .rsp  (rsp)
  );

  // Only one word is ever in flight.
  assert property (@(posedge clk) disable iff (rst) !(cmd_ready && rsp_valid))
    else $error("command taken while a response is pending");

  // A taken response frees the block for the next command.
  assert property (@(posedge clk) disable iff (rst) (rsp_valid && rsp_ready) |=> cmd_ready)
    else $error("block not ready after response handoff");

  // A command never produces a response in the very next cycle.
  assert property (@(posedge clk) disable iff (rst) (cmd_valid && cmd_ready) |=> !rsp_valid)
    else $error("response appeared before the slot walk");

  // Counts never exceed the bank size.
  assert property (@(posedge clk) disable iff (rst)
      rsp_valid |-> (32'(rsp.running_count) <= cdt_pkg::SLOTS &&
                     32'(rsp.affected_count) <= cdt_pkg::SLOTS))
    else $error("slot count exceeds bank size");

endmodule

>>> hw/rtl/cdt_ctrl.sv
`timescale 1ns / 1ps
// Sequencing controller: takes a command word, walks the slots, hands off the response.
module cdt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  cdt_pkg::dp_stat_t   stat,
  output cdt_pkg::ctrl_cmd_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_WALK;
      end
      S_WALK: begin
        if (stat.last) state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cmd_ready  = (state == S_IDLE);
  assign rsp_valid  = (state == S_DONE);
  assign ctl.load   = (state == S_IDLE) && cmd_valid;
  assign ctl.step   = (state == S_WALK);
  assign ctl.finish = (state == S_WALK) && stat.last;

endmodule

>>> hw/rtl/cdt_dp.sv
`timescale 1ns / 1ps
// Slot storage and the per-slot update logic, visited one slot per cycle.
module cdt_dp (
  input  logic                clk,
  input  logic                rst,
  input  cdt_pkg::cmd_t       cmd,
  input  cdt_pkg::ctrl_cmd_t  ctl,
  output cdt_pkg::dp_stat_t   stat,
  output cdt_pkg::rsp_t       rsp
);

  logic                        used [cdt_pkg::SLOTS];
  cdt_pkg::phase_t             phase [cdt_pkg::SLOTS];
  logic [1:0]                  kind [cdt_pkg::SLOTS];
  logic [8:0]                  mins [cdt_pkg::SLOTS];
  logic [14:0]                 secs [cdt_pkg::SLOTS];

  logic [cdt_pkg::SLOT_W-1:0]  cnt;
  cdt_pkg::mode_t              mode;
  logic [2:0]                  idx;
  logic [1:0]                  kind_in;
  logic [8:0]                  mins_in;
  logic                        args_ok;
  logic                        claimed;
  cdt_pkg::status_t            status, status_next;
  logic [2:0]                  rslot, rslot_next;
  logic [2:0]                  q_state, q_state_next;
  logic [1:0]                  q_type, q_type_next;
  logic [8:0]                  q_dur, q_dur_next;
  logic [14:0]                 q_rem, q_rem_next;
  logic [cdt_pkg::CNT_W-1:0]   run_cnt, run_cnt_next;
  logic [cdt_pkg::CNT_W-1:0]   aff_cnt, aff_cnt_next;

  // Current slot and its update.
  logic                        cur_used, used_new;
  cdt_pkg::phase_t             cur_ph, ph_new;
  logic [14:0]                 cur_sec, sec_new, sec_dec;
  logic                        claim, hit, aff_inc;
  cdt_pkg::status_t            final_status;

  assign cur_used = used[cnt];
  assign cur_ph   = phase[cnt];
  assign cur_sec  = secs[cnt];
  assign hit      = (cdt_pkg::IDX_W'(cnt) == cdt_pkg::IDX_W'(idx));
  assign claim    = (mode == cdt_pkg::MODE_CREATE) && args_ok && !claimed && !cur_used;
  assign sec_dec  = (cur_sec != 15'd0) ? cur_sec - 15'd1 : 15'd0;

  assign stat.last = (32'(cnt) == cdt_pkg::SLOTS - 1);

  always_comb begin
    used_new     = cur_used;
    ph_new       = cur_ph;
    sec_new      = cur_sec;
    aff_inc      = 1'b0;
    status_next  = status;
    rslot_next   = rslot;
    q_state_next = q_state;
    q_type_next  = q_type;
    q_dur_next   = q_dur;
    q_rem_next   = q_rem;
    case (mode)
      cdt_pkg::MODE_CREATE: begin
        if (claim) begin
          used_new    = 1'b1;
          ph_new      = cdt_pkg::PH_IDLE;
          sec_new     = 15'(15'(mins_in) * cdt_pkg::SECS_PER_MIN);
          status_next = cdt_pkg::ST_OK;
          rslot_next  = 3'(cnt);
        end
      end
      cdt_pkg::MODE_STOP_ALL: begin
        if (cur_used && (cur_ph inside {cdt_pkg::PH_IDLE, cdt_pkg::PH_RUN,
                                        cdt_pkg::PH_PAUSE})) begin
          used_new = 1'b0;
          ph_new   = cdt_pkg::PH_CANCEL;
          aff_inc  = 1'b1;
        end
      end
      cdt_pkg::MODE_TICK: begin
        if (cur_used && cur_ph == cdt_pkg::PH_RUN) begin
          sec_new = sec_dec;
          if (sec_dec == 15'd0) begin
            ph_new  = cdt_pkg::PH_DONE;
            aff_inc = 1'b1;
          end
        end
      end
      default: begin
        // Single-slot commands act only when the walk reaches the addressed slot.
        if (hit) begin
          if (!cur_used) begin
            status_next = cdt_pkg::ST_NOTFOUND;
          end else begin
            status_next = cdt_pkg::ST_OK;
            case (mode)
              cdt_pkg::MODE_START: begin
                if (cur_ph == cdt_pkg::PH_IDLE) ph_new = cdt_pkg::PH_RUN;
                else status_next = cdt_pkg::ST_STATE;
              end
              cdt_pkg::MODE_PAUSE: begin
                if (cur_ph == cdt_pkg::PH_RUN) ph_new = cdt_pkg::PH_PAUSE;
                else status_next = cdt_pkg::ST_STATE;
              end
              cdt_pkg::MODE_RESUME: begin
                if (cur_ph == cdt_pkg::PH_PAUSE) ph_new = cdt_pkg::PH_RUN;
                else status_next = cdt_pkg::ST_STATE;
              end
              cdt_pkg::MODE_STOP: begin
                used_new = 1'b0;
                ph_new   = cdt_pkg::PH_CANCEL;
              end
              default: begin
                q_state_next = cur_ph;
                q_type_next  = kind[cnt];
                q_dur_next   = mins[cnt];
                q_rem_next   = cur_sec;
              end
            endcase
          end
        end
      end
    endcase
  end

  assign run_cnt_next = run_cnt +
      cdt_pkg::CNT_W'(used_new && ph_new == cdt_pkg::PH_RUN);
  assign aff_cnt_next = aff_cnt + cdt_pkg::CNT_W'(aff_inc);

  always_comb begin
    final_status = status_next;
    if (mode == cdt_pkg::MODE_STOP_ALL) begin
      final_status = (aff_cnt_next != '0) ? cdt_pkg::ST_OK : cdt_pkg::ST_NOTFOUND;
    end
  end

  // Control and used flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cdt_pkg::SLOTS; i++) used[i] <= 1'b0;
      cnt     <= '0;
      claimed <= 1'b0;
    end else if (ctl.load) begin
      cnt     <= '0;
      claimed <= 1'b0;
    end else if (ctl.step) begin
      used[cnt] <= used_new;
      if (claim) claimed <= 1'b1;
      if (!stat.last) cnt <= cnt + cdt_pkg::SLOT_W'(1);
    end
  end

  // Slot contents, valid only while the slot is used.
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      phase[cnt] <= ph_new;
      secs[cnt]  <= sec_new;
      if (claim) begin
        kind[cnt] <= kind_in;
        mins[cnt] <= mins_in;
      end
    end
  end

  // Per-word working registers and the response word.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mode    <= cdt_pkg::mode_t'(cmd.mode);
      idx     <= cmd.slot_index;
      kind_in <= cmd.task_type;
      mins_in <= cmd.length_minutes;
      args_ok <= cmd.length_minutes inside {[9'd1:cdt_pkg::MAX_MINUTES]};
      rslot   <= 3'd0;
      q_state <= 3'd0;
      q_type  <= 2'd0;
      q_dur   <= 9'd0;
      q_rem   <= 15'd0;
      run_cnt <= '0;
      aff_cnt <= '0;
      case (cdt_pkg::mode_t'(cmd.mode))
        cdt_pkg::MODE_CREATE: begin
          if (cmd.length_minutes inside {[9'd1:cdt_pkg::MAX_MINUTES]}) status <= cdt_pkg::ST_FULL;
          else status <= cdt_pkg::ST_ARG;
        end
        cdt_pkg::MODE_STOP_ALL, cdt_pkg::MODE_TICK: status <= cdt_pkg::ST_OK;
        default: begin
          // An index that no slot matches stays an argument error.
          status <= cdt_pkg::ST_ARG;
          rslot  <= cmd.slot_index;
        end
      endcase
    end else if (ctl.step) begin
      status  <= status_next;
      rslot   <= rslot_next;
      q_state <= q_state_next;
      q_type  <= q_type_next;
      q_dur   <= q_dur_next;
      q_rem   <= q_rem_next;
      run_cnt <= run_cnt_next;
      aff_cnt <= aff_cnt_next;
    end
    if (ctl.finish) begin
      rsp.status         <= final_status;
      rsp.result_slot    <= rslot_next;
      rsp.slot_state     <= q_state_next;
      rsp.slot_type      <= q_type_next;
      rsp.slot_duration  <= q_dur_next;
      rsp.slot_remaining <= q_rem_next;
      rsp.running_count  <= cdt_pkg::sat4(run_cnt_next);
      rsp.affected_count <= ((mode == cdt_pkg::MODE_STOP_ALL) || (mode == cdt_pkg::MODE_TICK))
                            ? cdt_pkg::sat4(aff_cnt_next) : 4'd0;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the countdown timer slot bank.
module testbench;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * cdt_pkg::SLOTS + 4;

  logic          clk;
  logic          rst       = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_ready;
  cdt_pkg::cmd_t cmd       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  cdt_pkg::rsp_t rsp;

  // Shadow copy of the slot bank, updated as each command word is accepted.
  bit              bank_used      [cdt_pkg::SLOTS];
  cdt_pkg::phase_t bank_phase     [cdt_pkg::SLOTS];
  logic [1:0]      bank_kind      [cdt_pkg::SLOTS];
  logic [8:0]      bank_minutes   [cdt_pkg::SLOTS];
  logic [14:0]     bank_secs_left [cdt_pkg::SLOTS];

  cdt_pkg::rsp_t pending_rsp[$];
  cdt_pkg::rsp_t expected_word;

  int   cmd_stall_pct;
  int   rsp_stall_pct;
  logic hold_req = 1'b0;
  int   hold_left;
  int   idle_cycles;

  int errors;
  int words_sent;
  int words_checked;
  int completions;
  int full_rejects;

  countdown_timer_slot_bank u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] clip15(input int n);
    return (n > 15) ? 4'd15 : 4'(n);
  endfunction

  // Applies one command to the shadow bank and returns the response word it should produce.
  function automatic cdt_pkg::rsp_t next_response(input cdt_pkg::cmd_t c);
    cdt_pkg::rsp_t r;
    int            idx;
    int            hits;
    int            running;
    r       = '0;
    idx     = int'(c.slot_index);
    hits    = 0;
    running = 0;
    case (c.mode)
      cdt_pkg::MODE_CREATE: begin
        if (!(c.length_minutes inside {[9'd1:cdt_pkg::MAX_MINUTES]})) begin
          r.status = cdt_pkg::ST_ARG;
        end else begin
          r.status = cdt_pkg::ST_FULL;
          for (int i = 0; i < cdt_pkg::SLOTS; i++) begin
            if (!bank_used[i] && r.status == cdt_pkg::ST_FULL) begin
              bank_used[i]      = 1'b1;
              bank_phase[i]     = cdt_pkg::PH_IDLE;
              bank_kind[i]      = c.task_type;
              bank_minutes[i]   = c.length_minutes;
              bank_secs_left[i] = 15'(c.length_minutes) * cdt_pkg::SECS_PER_MIN;
              r.status          = cdt_pkg::ST_OK;
              r.result_slot     = 3'(i);
            end
          end
          if (r.status == cdt_pkg::ST_FULL) full_rejects++;
        end
      end
      cdt_pkg::MODE_STOP_ALL: begin
        for (int i = 0; i < cdt_pkg::SLOTS; i++) begin
          if (bank_used[i] && (bank_phase[i] inside {cdt_pkg::PH_IDLE, cdt_pkg::PH_RUN,
                                                     cdt_pkg::PH_PAUSE})) begin
            bank_phase[i] = cdt_pkg::PH_CANCEL;
            bank_used[i]  = 1'b0;
            hits++;
          end
        end
        r.status = (hits != 0) ? cdt_pkg::ST_OK : cdt_pkg::ST_NOTFOUND;
      end
      cdt_pkg::MODE_TICK: begin
        for (int i = 0; i < cdt_pkg::SLOTS; i++) begin
          if (bank_used[i] && bank_phase[i] == cdt_pkg::PH_RUN) begin
            if (bank_secs_left[i] != 0) bank_secs_left[i] = bank_secs_left[i] - 1'b1;
            if (bank_secs_left[i] == 0) begin
              bank_phase[i] = cdt_pkg::PH_DONE;
              hits++;
            end
          end
        end
        completions += hits;
      end
      default: begin
        r.result_slot = c.slot_index;
        if (idx >= cdt_pkg::SLOTS) begin
          r.status = cdt_pkg::ST_ARG;
        end else if (!bank_used[idx]) begin
          r.status = cdt_pkg::ST_NOTFOUND;
        end else begin
          case (c.mode)
            cdt_pkg::MODE_START: begin
              if (bank_phase[idx] == cdt_pkg::PH_IDLE) bank_phase[idx] = cdt_pkg::PH_RUN;
              else r.status = cdt_pkg::ST_STATE;
            end
            cdt_pkg::MODE_PAUSE: begin
              if (bank_phase[idx] == cdt_pkg::PH_RUN) bank_phase[idx] = cdt_pkg::PH_PAUSE;
              else r.status = cdt_pkg::ST_STATE;
            end
            cdt_pkg::MODE_RESUME: begin
              if (bank_phase[idx] == cdt_pkg::PH_PAUSE) bank_phase[idx] = cdt_pkg::PH_RUN;
              else r.status = cdt_pkg::ST_STATE;
            end
            cdt_pkg::MODE_STOP: begin
              bank_phase[idx] = cdt_pkg::PH_CANCEL;
              bank_used[idx]  = 1'b0;
            end
            default: begin
              r.slot_state     = bank_phase[idx];
              r.slot_type      = bank_kind[idx];
              r.slot_duration  = bank_minutes[idx];
              r.slot_remaining = bank_secs_left[idx];
            end
          endcase
        end
      end
    endcase
    for (int i = 0; i < cdt_pkg::SLOTS; i++) begin
      if (bank_used[i] && bank_phase[i] == cdt_pkg::PH_RUN) running++;
    end
    r.running_count  = clip15(running);
    r.affected_count = clip15(hits);
    return r;
  endfunction

  // Prefers slots that are in use so that most commands get past the lookup.
  function automatic int pick_slot();
    int live[$];
    for (int i = 0; i < cdt_pkg::SLOTS; i++) begin
      if (bank_used[i]) live.push_back(i);
    end
    if (live.size() != 0 && $urandom_range(3) != 0) return live[$urandom_range(live.size() - 1)];
    return $urandom_range(7);
  endfunction

  // Mostly short countdowns so that slots actually run out, plus edges and out-of-range noise.
  function automatic int pick_minutes();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return $urandom_range(2, 1);
    if (roll < 70) return $urandom_range(480, 3);
    if (roll < 80) return (roll < 75) ? 1 : 480;
    return $urandom_range(511);
  endfunction

  // Offers one command word and records its expected response once it is taken.
  task automatic send_word(input cdt_pkg::mode_t m, input int idx, input int kind,
                           input int mins);
    cdt_pkg::cmd_t c;
    c.mode           = m;
    c.slot_index     = 3'(idx);
    c.task_type      = 2'(kind);
    c.length_minutes = 9'(mins);
    @(posedge clk);
    while ($urandom_range(99) < cmd_stall_pct) @(posedge clk);
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    pending_rsp.push_back(next_response(c));
    words_sent++;
    cmd_valid <= 1'b0;
  endtask

  task automatic send_op(input cdt_pkg::mode_t m, input int idx);
    send_word(m, idx, $urandom_range(3), $urandom_range(511));
  endtask

  task automatic send_random_word();
    int             roll;
    cdt_pkg::mode_t m;
    roll = $urandom_range(99);
    if (roll < 18) m = cdt_pkg::MODE_CREATE;
    else if (roll < 30) m = cdt_pkg::MODE_START;
    else if (roll < 35) m = cdt_pkg::MODE_PAUSE;
    else if (roll < 41) m = cdt_pkg::MODE_RESUME;
    else if (roll < 44) m = cdt_pkg::MODE_STOP;
    else if (roll < 45) m = cdt_pkg::MODE_STOP_ALL;
    else if (roll < 54) m = cdt_pkg::MODE_QUERY;
    else m = cdt_pkg::MODE_TICK;
    if (m == cdt_pkg::MODE_CREATE) begin
      send_word(m, $urandom_range(7), $urandom_range(3), pick_minutes());
    end else begin
      send_word(m, pick_slot(), $urandom_range(3), $urandom_range(511));
    end
  endtask

  task automatic test_directed();
    send_op(cdt_pkg::MODE_STOP_ALL, 0);
    send_word(cdt_pkg::MODE_CREATE, 0, 2, 0);
    send_word(cdt_pkg::MODE_CREATE, 0, 1, 481);
    send_word(cdt_pkg::MODE_CREATE, 0, 3, 511);
    send_word(cdt_pkg::MODE_CREATE, 0, 3, 480);
    for (int i = 1; i < cdt_pkg::SLOTS; i++) send_word(cdt_pkg::MODE_CREATE, 0, i % 4, i);
    send_word(cdt_pkg::MODE_CREATE, 0, 0, 1);
    send_op(cdt_pkg::MODE_START, 0);
    send_op(cdt_pkg::MODE_START, 0);
    send_op(cdt_pkg::MODE_RESUME, 0);
    send_op(cdt_pkg::MODE_PAUSE, 0);
    send_op(cdt_pkg::MODE_PAUSE, 0);
    send_op(cdt_pkg::MODE_RESUME, 0);
    send_op(cdt_pkg::MODE_TICK, 0);
    send_op(cdt_pkg::MODE_QUERY, 0);
    send_op(cdt_pkg::MODE_STOP, 1);
    send_op(cdt_pkg::MODE_QUERY, 1);
    send_op(cdt_pkg::MODE_START, 1);
    send_op(cdt_pkg::MODE_PAUSE, 1);
    send_op(cdt_pkg::MODE_RESUME, 1);
    send_op(cdt_pkg::MODE_STOP, 1);
    send_op(cdt_pkg::MODE_STOP_ALL, 0);
  endtask

  // Runs one-minute slots down to zero, then pokes the completed slots.
  task automatic test_countdown();
    int n;
    for (int i = 0; i < cdt_pkg::SLOTS; i++) send_op(cdt_pkg::MODE_STOP, i);
    n = $urandom_range(4, 1);
    for (int i = 0; i < n; i++) send_word(cdt_pkg::MODE_CREATE, 0, $urandom_range(3), 1);
    send_word(cdt_pkg::MODE_CREATE, 0, $urandom_range(3), 2);
    for (int i = 0; i <= n; i++) send_op(cdt_pkg::MODE_START, i);
    send_op(cdt_pkg::MODE_TICK, $urandom_range(7));
    send_op(cdt_pkg::MODE_PAUSE, 0);
    send_op(cdt_pkg::MODE_TICK, $urandom_range(7));
    send_op(cdt_pkg::MODE_RESUME, 0);
    repeat (60) send_op(cdt_pkg::MODE_TICK, $urandom_range(7));
    for (int i = 0; i <= n; i++) send_op(cdt_pkg::MODE_QUERY, i);
    send_op(cdt_pkg::MODE_START, 0);
    send_op(cdt_pkg::MODE_PAUSE, 0);
    send_op(cdt_pkg::MODE_RESUME, 0);
    // The first stop-all frees only the two-minute slot; completed slots survive it.
    send_op(cdt_pkg::MODE_STOP_ALL, 0);
    send_op(cdt_pkg::MODE_STOP_ALL, 0);
    for (int i = 0; i < n; i++) send_op(cdt_pkg::MODE_STOP, i);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random_word();
  endtask

  // The receiver holds off while words keep coming, so the block has to stall its input.
  task automatic test_backpressure();
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (12) send_random_word();
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response word arrived with no command outstanding");
        errors++;
      end else begin
        expected_word = pending_rsp.pop_front();
        check_field("status", expected_word.status, rsp.status);
        check_field("result_slot", expected_word.result_slot, rsp.result_slot);
        check_field("slot_state", expected_word.slot_state, rsp.slot_state);
        check_field("slot_type", expected_word.slot_type, rsp.slot_type);
        check_field("slot_duration", expected_word.slot_duration, rsp.slot_duration);
        check_field("slot_remaining", expected_word.slot_remaining, rsp.slot_remaining);
        check_field("running_count", expected_word.running_count, rsp.running_count);
        check_field("affected_count", expected_word.affected_count, rsp.affected_count);
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("No handshake for %0d cycles, %0d responses outstanding",
               idle_cycles, pending_rsp.size());
      $display("countdown_timer_slot_bank test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    cmd_stall_pct = 8;
    rsp_stall_pct = 56;
    test_directed();
    test_countdown();
    test_random(300);

    cmd_stall_pct = 56;
    rsp_stall_pct = 8;
    test_backpressure();
    test_random(300);

    cmd_stall_pct = 0;
    rsp_stall_pct = 0;
    test_random(250);
    test_countdown();

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d command words and checked %0d responses under three stall profiles",
             words_sent, words_checked);
    $display("and one long receiver hold; %0d slots ran out, %0d creates found the bank full.",
             completions, full_rejects);
    if (errors == 0) begin
      $display("countdown_timer_slot_bank test passed");
    end else begin
      $display("countdown_timer_slot_bank test failed");
    end
    $finish;
  end

endmodule
